@@ rtl/core/pbre_pkg.sv @@
// ----------------------------------------------------------------------------
// PE base relocation engine package
// Shared widths, result kinds and the result record passed between stages.
// ----------------------------------------------------------------------------
package pbre_pkg;

  localparam int unsigned AddrW   = 32;
  localparam int unsigned HalfW   = 16;
  localparam int unsigned KindW   = 2;
  localparam int unsigned CountW  = 31;
  localparam int unsigned OffsetW = 12;

  localparam logic [KindW-1:0] KindPatch   = 2'd0;
  localparam logic [KindW-1:0] KindBadType = 2'd1;
  localparam logic [KindW-1:0] KindBadSize = 2'd2;

  localparam logic [3:0] TypeAbsolute = 4'd0;
  localparam logic [3:0] TypeHighLow  = 4'd3;

  localparam logic CfgIdxLoad = 1'b0;
  localparam logic CfgIdxPref = 1'b1;

  // Minimum legal block size: the eight byte block header.
  localparam logic [AddrW-1:0] MinBlockSize = 32'd8;

  typedef struct packed {
    logic             valid;
    logic [KindW-1:0] kind;
    logic [AddrW-1:0] patch_address;
    logic [AddrW-1:0] addend;
  } result_t;

endpackage

@@ rtl/core/pe_base_relocation_engine.sv @@
// ----------------------------------------------------------------------------
// PE base relocation engine
// Parses a PE base relocation directory and emits HIGHLOW patch commands and error results.
// ----------------------------------------------------------------------------
// Takes one directory halfword per clock and gives its result, if any, in the
// next cycle through a single output register; a new halfword is taken in
// every cycle unless that register still holds a result the sink has not
// taken. Padding entries and block headers give no result; a bad entry type
// or a malformed block size gives one error result and stops the parser until
// a halfword arrives with the restart flag. While load_address equals
// preferred_base no results leave the block. Write the two address registers
// only while the stream is idle.
module pe_base_relocation_engine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [pbre_pkg::AddrW-1:0]  cfg_wdata_i,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [pbre_pkg::HalfW-1:0]  s_axis_tdata_i,   // [15:0] halfword
  input  logic                        s_axis_tuser_i,   // [0] restart
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [2*pbre_pkg::AddrW-1:0] m_axis_tdata_o,  // [31:0] patch_address, [63:32] addend
  output logic [pbre_pkg::KindW-1:0]  m_axis_tuser_o    // [1:0] kind
);

  logic [pbre_pkg::AddrW-1:0] load_address_q;
  logic [pbre_pkg::AddrW-1:0] preferred_base_q;
  logic                       in_accept;
  logic                       out_free;
  pbre_pkg::result_t          result;
  logic [pbre_pkg::AddrW-1:0] patch_address;
  logic [pbre_pkg::AddrW-1:0] addend;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_address_q   <= '0;
      preferred_base_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pbre_pkg::CfgIdxLoad: load_address_q   <= cfg_wdata_i;
        pbre_pkg::CfgIdxPref: preferred_base_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready_o = out_free;
  assign in_accept       = s_axis_tvalid_i && out_free;

  pbre_parse u_parse (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (in_accept),
    .restart_i        (s_axis_tuser_i),
    .halfword_i       (s_axis_tdata_i),
    .load_address_i   (load_address_q),
    .preferred_base_i (preferred_base_q),
    .result_o         (result)
  );

  pbre_out_reg u_out_reg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (in_accept),
    .result_i        (result),
    .take_i          (m_axis_tready_i),
    .free_o          (out_free),
    .valid_o         (m_axis_tvalid_o),
    .kind_o          (m_axis_tuser_o),
    .patch_address_o (patch_address),
    .addend_o        (addend)
  );

  assign m_axis_tdata_o = {addend, patch_address};

  a_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input taken while a result is stalled");

  a_zero_delta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_address_q == preferred_base_q) |-> !result.valid)
    else $error("result formed with zero delta");

endmodule

@@ rtl/core/pbre_parse.sv @@
// ----------------------------------------------------------------------------
// PE base relocation parser
// Walks the relocation directory one halfword per transaction and forms the
// patch or error result, if any, for the halfword.
// ----------------------------------------------------------------------------
module pbre_parse (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic                         restart_i,
  input  logic [pbre_pkg::HalfW-1:0]   halfword_i,
  input  logic [pbre_pkg::AddrW-1:0]   load_address_i,
  input  logic [pbre_pkg::AddrW-1:0]   preferred_base_i,
  output pbre_pkg::result_t            result_o
);

  localparam logic [2:0] PhPageLo = 3'd0;
  localparam logic [2:0] PhPageHi = 3'd1;
  localparam logic [2:0] PhSizeLo = 3'd2;
  localparam logic [2:0] PhSizeHi = 3'd3;
  localparam logic [2:0] PhEntry  = 3'd4;

  logic [2:0]                  phase_q, phase_d;
  logic [pbre_pkg::AddrW-1:0]  page_q, page_d;
  logic [pbre_pkg::HalfW-1:0]  size_lo_q, size_lo_d;
  logic [pbre_pkg::CountW-1:0] entries_q, entries_d;
  logic                        halted_q, halted_d;

  logic [2:0]                  phase_eff;
  logic [pbre_pkg::CountW-1:0] entries_eff;
  logic                        halted_eff;
  logic [pbre_pkg::AddrW-1:0]  size;
  logic [pbre_pkg::AddrW-1:0]  size_body;
  logic [pbre_pkg::CountW-1:0] entries_dec;
  logic [3:0]                  entry_type;
  logic [pbre_pkg::AddrW-1:0]  offset_ext;
  logic                        emit;
  logic                        delta_zero;
  pbre_pkg::result_t           res;

  assign phase_eff   = restart_i ? PhPageLo : phase_q;
  assign entries_eff = restart_i ? '0 : entries_q;
  assign halted_eff  = restart_i ? 1'b0 : halted_q;
  assign size        = {halfword_i, size_lo_q};
  assign size_body   = size - pbre_pkg::MinBlockSize;
  assign entries_dec = entries_eff - pbre_pkg::CountW'(1);
  assign entry_type  = halfword_i[pbre_pkg::HalfW-1 -: 4];
  assign offset_ext  = {{(pbre_pkg::AddrW-pbre_pkg::OffsetW){1'b0}},
                        halfword_i[pbre_pkg::OffsetW-1:0]};
  assign delta_zero  = (load_address_i == preferred_base_i);

  always_comb begin
    phase_d   = phase_eff;
    page_d    = page_q;
    size_lo_d = size_lo_q;
    entries_d = entries_eff;
    halted_d  = halted_eff;
    emit      = 1'b0;
    res.kind          = pbre_pkg::KindPatch;
    res.patch_address = '0;
    res.addend        = '0;
    if (!halted_eff) begin
      unique case (phase_eff)
        PhPageHi: begin
          page_d  = {halfword_i, page_q[pbre_pkg::HalfW-1:0]};
          phase_d = PhSizeLo;
        end
        PhSizeLo: begin
          size_lo_d = halfword_i;
          phase_d   = PhSizeHi;
        end
        PhSizeHi: begin
          if (size < pbre_pkg::MinBlockSize || size[0]) begin
            halted_d  = 1'b1;
            phase_d   = PhPageLo;
            entries_d = '0;
            emit      = 1'b1;
            res.kind  = pbre_pkg::KindBadSize;
          end else begin
            entries_d = size_body[pbre_pkg::AddrW-1:1];
            phase_d   = (size_body[pbre_pkg::AddrW-1:1] != '0) ? PhEntry : PhPageLo;
          end
        end
        PhEntry: begin
          entries_d = entries_dec;
          if (entries_dec == '0) begin
            phase_d = PhPageLo;
          end
          if (entry_type == pbre_pkg::TypeAbsolute) begin
            emit = 1'b0;
          end else if (entry_type == pbre_pkg::TypeHighLow) begin
            emit              = 1'b1;
            res.patch_address = load_address_i + page_q + offset_ext;
            res.addend        = load_address_i - preferred_base_i;
          end else begin
            halted_d  = 1'b1;
            phase_d   = PhPageLo;
            entries_d = '0;
            emit      = 1'b1;
            res.kind  = pbre_pkg::KindBadType;
          end
        end
        default: begin
          // page low half; an impossible phase code lands here too
          page_d  = {{pbre_pkg::HalfW{1'b0}}, halfword_i};
          phase_d = PhPageHi;
        end
      endcase
    end
    res.valid = emit && !delta_zero;
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhPageLo;
      page_q    <= '0;
      size_lo_q <= '0;
      entries_q <= '0;
      halted_q  <= 1'b0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      page_q    <= page_d;
      size_lo_q <= size_lo_d;
      entries_q <= entries_d;
      halted_q  <= halted_d;
    end
  end

  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (halted_q && !restart_i) |-> !result_o.valid)
    else $error("halted parser produced a result");

  a_halt_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> (phase_q == PhPageLo && entries_q == '0))
    else $error("halted parser left parse state behind");

endmodule

@@ rtl/core/pbre_out_reg.sv @@
// ----------------------------------------------------------------------------
// PE base relocation result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module pbre_out_reg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  pbre_pkg::result_t           result_i,
  input  logic                        take_i,
  output logic                        free_o,
  output logic                        valid_o,
  output logic [pbre_pkg::KindW-1:0]  kind_o,
  output logic [pbre_pkg::AddrW-1:0]  patch_address_o,
  output logic [pbre_pkg::AddrW-1:0]  addend_o
);

  logic                       valid_q, valid_d;
  logic [pbre_pkg::KindW-1:0] kind_q;
  logic [pbre_pkg::AddrW-1:0] addr_q;
  logic [pbre_pkg::AddrW-1:0] addend_q;

  assign free_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = result_i.valid;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && result_i.valid) begin
      kind_q   <= result_i.kind;
      addr_q   <= result_i.patch_address;
      addend_q <= result_i.addend;
    end
  end

  assign valid_o         = valid_q;
  assign kind_o          = kind_q;
  assign patch_address_o = addr_q;
  assign addend_o        = addend_q;

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_i && result_i.valid) |=> valid_q)
    else $error("loaded result not presented");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && kind_q != pbre_pkg::KindPatch) |-> (addr_q == '0 && addend_q == '0))
    else $error("error result carries a nonzero payload");

endmodule
